// ===== sv/traffic_light_go_confidence_top_macros.svh =====
// Assertion macros shared by the go-confidence RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef TRAFFIC_LIGHT_GO_CONFIDENCE_TOP_MACROS_SVH
`define TRAFFIC_LIGHT_GO_CONFIDENCE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TLGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tlgc_pkg.sv =====
// Shared types and constants for the traffic light go-confidence block.
// No dependencies.
package tlgc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int LEVEL_BITS     = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROI_LEFT,
        REG_ROI_RIGHT,
        REG_ROI_TOP,
        REG_ROI_BOTTOM
    } t_cfg_reg;

    localparam logic [LEVEL_BITS-1:0] LVL_STRONG_STOP = 3'd0;
    localparam logic [LEVEL_BITS-1:0] LVL_STOP        = 3'd1;
    localparam logic [LEVEL_BITS-1:0] LVL_CAUTION     = 3'd2;
    localparam logic [LEVEL_BITS-1:0] LVL_GO          = 3'd3;
    localparam logic [LEVEL_BITS-1:0] LVL_STRONG_GO   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MULK,
        S_MULR,
        S_CORR,
        S_OUT
    } t_seq_state;

    // confidence update steps, applied in this priority order
    typedef enum logic [1:0] {
        OP_PULL,
        OP_RED_IN,
        OP_RED_OUT,
        OP_GREEN
    } t_op;

    typedef struct packed {
        logic start;  // clamp confidence, latch pending steps
        logic mulk;   // x = k * operand + rounding
        logic mulr;   // q estimate = x * reciprocal
        logic corr;   // correct q, write confidence
        logic done;   // load result register, clear counters
    } t_seq_ctl;

    typedef struct packed {
        logic red_in;
        logic red_out;
        logic green_in;
    } t_cnt_flags;

endpackage

// ===== sv/tlgc_if.sv =====
// Handshake interfaces for box input, result output and register writes.
// Depends on tlgc_pkg for default widths.
interface tlgc_in_if #(
    parameter int COORD_BITS = tlgc_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  has_component;
    logic                  is_green;
    logic                  filtered;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y;
    logic                  end_of_frame;

    modport source (output valid, has_component, is_green, filtered,
                    min_x, max_x, min_y, max_y, end_of_frame, input ready);
    modport sink   (input valid, has_component, is_green, filtered,
                    min_x, max_x, min_y, max_y, end_of_frame, output ready);
endinterface

interface tlgc_out_if #(
    parameter int FRAC_BITS  = tlgc_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = tlgc_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [FRAC_BITS:0]    go_confidence;
    logic [2:0]            go_level;
    logic [COUNT_BITS-1:0] red_inside_total;
    logic [COUNT_BITS-1:0] green_inside_total;

    modport source (output valid, go_confidence, go_level, red_inside_total,
                    green_inside_total, input ready);
    modport sink   (input valid, go_confidence, go_level, red_inside_total,
                    green_inside_total, output ready);
endinterface

interface tlgc_cfg_if #(
    parameter int COORD_BITS = tlgc_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [tlgc_pkg::CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tlgc_boxcnt.sv =====
// Region-of-interest test and saturating per-frame box counters.
// Depends on tlgc_pkg and the assertion macro header.
`include "traffic_light_go_confidence_top_macros.svh"

module tlgc_boxcnt #(
    parameter int COORD_BITS = tlgc_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = tlgc_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic                  i_has,
    input  logic                  i_green,
    input  logic                  i_filt,
    input  logic [COORD_BITS-1:0] i_min_x,
    input  logic [COORD_BITS-1:0] i_max_x,
    input  logic [COORD_BITS-1:0] i_min_y,
    input  logic [COORD_BITS-1:0] i_max_y,
    input  logic [COORD_BITS-1:0] i_roi_left,
    input  logic [COORD_BITS-1:0] i_roi_right,
    input  logic [COORD_BITS-1:0] i_roi_top,
    input  logic [COORD_BITS-1:0] i_roi_bottom,
    input  logic                  i_clr,
    output logic [COUNT_BITS-1:0] o_red_in,
    output logic [COUNT_BITS-1:0] o_green_in,
    output tlgc_pkg::t_cnt_flags  o_flags
);
    import tlgc_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_red_in, r_red_out, r_green_in;
    logic [COUNT_BITS-1:0] n_red_in, n_red_out, n_green_in;
    logic                  l_inside, l_count;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + COUNT_BITS'(1);
    endfunction

    // strictly inside the region on every edge
    assign l_inside = (i_min_x > i_roi_left) && (i_max_x < i_roi_right) &&
                      (i_min_y > i_roi_top)  && (i_max_y < i_roi_bottom);
    assign l_count  = i_acc && i_has && !i_filt;

    always_comb begin
        n_red_in   = r_red_in;
        n_red_out  = r_red_out;
        n_green_in = r_green_in;
        if (i_clr) begin
            n_red_in   = '0;
            n_red_out  = '0;
            n_green_in = '0;
        end else if (l_count) begin
            if (i_green) begin
                if (l_inside) n_green_in = sat_inc(r_green_in);
            end else if (l_inside) begin
                n_red_in = sat_inc(r_red_in);
            end else begin
                n_red_out = sat_inc(r_red_out);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_in   <= '0;
            r_red_out  <= '0;
            r_green_in <= '0;
        end else begin
            r_red_in   <= n_red_in;
            r_red_out  <= n_red_out;
            r_green_in <= n_green_in;
        end
    end

    assign o_red_in         = r_red_in;
    assign o_green_in       = r_green_in;
    assign o_flags.red_in   = (r_red_in != '0);
    assign o_flags.red_out  = (r_red_out != '0);
    assign o_flags.green_in = (r_green_in != '0);

    `TLGC_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !l_count && !i_clr, $stable(r_red_in) && $stable(r_red_out) && $stable(r_green_in), "counters moved without a box or clear")

endmodule

// ===== sv/tlgc_mdu.sv =====
// Shared multiply unit: k*c or k*(1-c) + rounding, then divide by ten through a
// reciprocal multiply and one correction step. Holds the confidence register.
// Depends on tlgc_pkg and the assertion macro header.
`include "traffic_light_go_confidence_top_macros.svh"

module tlgc_mdu #(
    parameter int FRAC_BITS = tlgc_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlgc_pkg::t_seq_ctl  i_ctl,
    input  tlgc_pkg::t_op       i_op,
    output logic [FRAC_BITS:0]  o_conf
);
    import tlgc_pkg::*;

    localparam int CW = FRAC_BITS + 1;
    localparam int XW = FRAC_BITS + 4;   // holds 9*ONE + ONE/2 + 5
    localparam logic [CW-1:0] ONE      = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] HALF     = ONE >> 1;
    localparam logic [XW-1:0] RND      = XW'(5);
    localparam logic [XW-1:0] ADD_PULL = XW'(HALF) + RND;
    localparam logic [XW-1:0] DIV_BASE = XW'(10);
    localparam logic [XW-1:0] K_NINE   = XW'(9);
    localparam logic [XW-1:0] K_SEVEN  = XW'(7);
    localparam logic [XW-1:0] RECIP    = XW'((64'd1 << XW) / 64'd10);

    logic [CW-1:0]   r_conf, n_conf;
    logic [XW-1:0]   r_x, r_qe;
    logic [XW-1:0]   l_opnd, l_k, l_add, l_mul_a, l_mul_b;
    logic [2*XW-1:0] l_prod;
    logic [XW-1:0]   l_q10, l_rem, l_q;
    logic [CW-1:0]   l_qc, l_res, l_clamp;

    always_comb begin
        l_opnd = (i_op == OP_GREEN) ? XW'(ONE - r_conf) : XW'(r_conf);
        l_k    = ((i_op == OP_PULL) || (i_op == OP_RED_OUT)) ? K_NINE : K_SEVEN;
        l_add  = (i_op == OP_PULL) ? ADD_PULL : RND;
    end

    // the one multiplier, used twice per step
    assign l_mul_a = i_ctl.mulk ? l_opnd : r_x;
    assign l_mul_b = i_ctl.mulk ? l_k : RECIP;
    assign l_prod  = l_mul_a * l_mul_b;

    // estimate is low by at most one
    always_comb begin
        l_q10   = (r_qe << 3) + (r_qe << 1);
        l_rem   = r_x - l_q10;
        l_q     = (l_rem >= DIV_BASE) ? r_qe + XW'(1) : r_qe;
        l_qc    = l_q[CW-1:0];
        l_res   = (i_op == OP_GREEN) ? ONE - l_qc : l_qc;
        n_conf  = (l_res > ONE) ? ONE : l_res;
        l_clamp = (r_conf > ONE) ? ONE : r_conf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf <= HALF;
        end else if (i_ctl.start) begin
            r_conf <= l_clamp;
        end else if (i_ctl.corr) begin
            r_conf <= n_conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mulk) r_x <= l_prod[XW-1:0] + l_add;
        if (i_ctl.mulr) r_qe <= l_prod[2*XW-1:XW];
    end

    assign o_conf = r_conf;

    `TLGC_ASSERT_IMP(a_conf_range, i_clk, i_rst_n, 1'b1, r_conf <= ONE, "confidence above one")
    `TLGC_ASSERT_NEXT(a_conf_hold, i_clk, i_rst_n, !i_ctl.start && !i_ctl.corr, $stable(r_conf), "confidence changed outside an update step")

endmodule

// ===== sv/tlgc_seq.sv =====
// Frame-end sequencer: orders the update steps on the shared multiply unit
// and hands the result to the output register. Depends on tlgc_pkg and macros.
`include "traffic_light_go_confidence_top_macros.svh"

module tlgc_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_eof_acc,
    input  tlgc_pkg::t_cnt_flags i_flags,
    input  logic                 i_out_free,
    output tlgc_pkg::t_seq_ctl   o_ctl,
    output tlgc_pkg::t_op        o_op,
    output logic                 o_idle
);
    import tlgc_pkg::*;

    t_seq_state r_state, n_state;
    logic r_pull, r_red, r_red_in, r_green;
    logic n_pull, n_red, n_red_in, n_green;
    logic l_any_new, l_more;
    t_op  l_op;

    // pending steps as they would be latched at start
    always_comb begin
        n_pull    = !i_flags.red_in && !i_flags.green_in;
        n_red     = i_flags.red_in || i_flags.red_out;
        n_red_in  = i_flags.red_in;
        n_green   = i_flags.green_in;
        l_any_new = n_pull || n_red || n_green;
    end

    always_comb begin
        if (r_pull)     l_op = OP_PULL;
        else if (r_red) l_op = r_red_in ? OP_RED_IN : OP_RED_OUT;
        else            l_op = OP_GREEN;
        l_more = r_pull ? (r_red || r_green) : (r_red ? r_green : 1'b0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_eof_acc) n_state = S_START;
            S_START: n_state = l_any_new ? S_MULK : S_OUT;
            S_MULK:  n_state = S_MULR;
            S_MULR:  n_state = S_CORR;
            S_CORR:  n_state = l_more ? S_MULK : S_OUT;
            S_OUT:   if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_ctl.start = (r_state == S_START);
        o_ctl.mulk  = (r_state == S_MULK);
        o_ctl.mulr  = (r_state == S_MULR);
        o_ctl.corr  = (r_state == S_CORR);
        o_ctl.done  = (r_state == S_OUT) && i_out_free;
        o_op        = l_op;
        o_idle      = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pull   <= 1'b0;
            r_red    <= 1'b0;
            r_red_in <= 1'b0;
            r_green  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_START) begin
                r_pull   <= n_pull;
                r_red    <= n_red;
                r_red_in <= n_red_in;
                r_green  <= n_green;
            end else if (r_state == S_CORR) begin
                // retire the step just finished
                if (r_pull)     r_pull  <= 1'b0;
                else if (r_red) r_red   <= 1'b0;
                else            r_green <= 1'b0;
            end
        end
    end

    `TLGC_ASSERT_IMP(a_corr_after_mul, i_clk, i_rst_n, r_state == S_CORR, $past(r_state) == S_MULR, "correction step without reciprocal multiply")
    `TLGC_ASSERT_IMP(a_out_no_pending, i_clk, i_rst_n, r_state == S_OUT, !r_pull && !r_red && !r_green, "result offered with update steps pending")

endmodule

// ===== sv/traffic_light_go_confidence_top.sv =====
// Traffic light go-confidence: a box or frame-end marker is accepted in every
// cycle while idle; boxes are sorted against the region of interest and counted
// in the accept cycle. A frame-end transaction then runs the confidence update
// on one shared multiplier: a clamp, one or two steps (each a multiply by 9 or 7
// with rounding, a multiply by the reciprocal of ten and a quotient correction),
// and a final load of the result register; input is not taken again until
// that load, which waits until the result register is free.
// Registers may be written at any time the block is idle.
// Depends on tlgc_pkg, tlgc_if, tlgc_boxcnt, tlgc_mdu and tlgc_seq.
module traffic_light_go_confidence_top #(
    parameter int COORD_BITS = tlgc_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = tlgc_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = tlgc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlgc_in_if.sink     i_item,
    tlgc_cfg_if.sink    i_cfg,
    tlgc_out_if.source  o_result
);
    import tlgc_pkg::*;

    localparam int CW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 5;
    localparam logic [TW-1:0] ONE_T  = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] THR_SG = (ONE_T << 3) + ONE_T;
    localparam logic [TW-1:0] THR_G  = (ONE_T << 3) - ONE_T;
    localparam logic [TW-1:0] THR_C  = ONE_T << 2;
    localparam logic [TW-1:0] THR_S  = (ONE_T << 1) + ONE_T;

    logic [COORD_BITS-1:0] r_roi_left, r_roi_right, r_roi_top, r_roi_bottom;
    logic                  r_out_valid;
    logic [CW-1:0]         r_out_conf;
    logic [2:0]            r_out_level;
    logic [COUNT_BITS-1:0] r_out_red, r_out_green;

    logic                  l_in_acc, l_cfg_acc, l_out_free, l_idle;
    logic [COUNT_BITS-1:0] l_red_in, l_green_in;
    logic [CW-1:0]         l_conf;
    logic [TW-1:0]         l_conf10;
    logic [2:0]            l_level;
    t_cnt_flags            l_flags;
    t_seq_ctl              l_ctl;
    t_op                   l_op;

    assign i_item.ready = l_idle;
    assign i_cfg.ready  = 1'b1;
    assign l_in_acc     = i_item.valid && i_item.ready;
    assign l_cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign l_out_free   = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roi_left   <= COORD_BITS'(256);
            r_roi_right  <= COORD_BITS'(1024);
            r_roi_top    <= '0;
            r_roi_bottom <= COORD_BITS'(360);
        end else if (l_cfg_acc) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_ROI_LEFT:   r_roi_left   <= i_cfg.data;
                REG_ROI_RIGHT:  r_roi_right  <= i_cfg.data;
                REG_ROI_TOP:    r_roi_top    <= i_cfg.data;
                REG_ROI_BOTTOM: r_roi_bottom <= i_cfg.data;
                default: ;
            endcase
        end
    end

    tlgc_boxcnt #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_boxcnt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (l_in_acc),
        .i_has        (i_item.has_component),
        .i_green      (i_item.is_green),
        .i_filt       (i_item.filtered),
        .i_min_x      (i_item.min_x),
        .i_max_x      (i_item.max_x),
        .i_min_y      (i_item.min_y),
        .i_max_y      (i_item.max_y),
        .i_roi_left   (r_roi_left),
        .i_roi_right  (r_roi_right),
        .i_roi_top    (r_roi_top),
        .i_roi_bottom (r_roi_bottom),
        .i_clr        (l_ctl.done),
        .o_red_in     (l_red_in),
        .o_green_in   (l_green_in),
        .o_flags      (l_flags)
    );

    tlgc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eof_acc  (l_in_acc && i_item.end_of_frame),
        .i_flags    (l_flags),
        .i_out_free (l_out_free),
        .o_ctl      (l_ctl),
        .o_op       (l_op),
        .o_idle     (l_idle)
    );

    tlgc_mdu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (l_ctl),
        .i_op    (l_op),
        .o_conf  (l_conf)
    );

    // levels compare 10*c against whole multiples of one
    always_comb begin
        l_conf10 = (TW'(l_conf) << 3) + (TW'(l_conf) << 1);
        if (l_conf10 > THR_SG)     l_level = LVL_STRONG_GO;
        else if (l_conf10 > THR_G) l_level = LVL_GO;
        else if (l_conf10 > THR_C) l_level = LVL_CAUTION;
        else if (l_conf10 > THR_S) l_level = LVL_STOP;
        else                       l_level = LVL_STRONG_STOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (l_ctl.done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_ctl.done) begin
            r_out_conf  <= l_conf;
            r_out_level <= l_level;
            r_out_red   <= l_red_in;
            r_out_green <= l_green_in;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.go_confidence      = r_out_conf;
    assign o_result.go_level           = r_out_level;
    assign o_result.red_inside_total   = r_out_red;
    assign o_result.green_inside_total = r_out_green;

endmodule

// ===== tb/tlgc_confidence_checker.sv =====
// Go-confidence checker: watches the box, register and result channels, keeps
// its own copy of the region, counters and confidence, and compares every result.
// Depends on tlgc_pkg and the channel interfaces in tlgc_if.
module tlgc_confidence_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tlgc_in_if   item_ch,
    tlgc_cfg_if  cfg_ch,
    tlgc_out_if  res_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import tlgc_pkg::*;

    localparam int                CW     = COORD_BITS_DEF;
    localparam int                NW     = COUNT_BITS_DEF;
    localparam int                FW     = FRAC_BITS_DEF;
    localparam longint unsigned   ONE    = 64'd1 << FW;
    localparam logic [NW-1:0]     CNT_MAX = '1;

    typedef struct {
        logic [FW:0]           conf;
        logic [LEVEL_BITS-1:0] level;
        logic [NW-1:0]         red_tot;
        logic [NW-1:0]         green_tot;
    } t_frame_result;

    t_frame_result frame_results_q[$];

    logic [CW-1:0] roi_l, roi_r, roi_t, roi_b;
    logic [FW:0]   conf;
    logic [NW-1:0] red_in_n, red_out_n, green_in_n;
    int            fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [NW-1:0] bump(logic [NW-1:0] n);
        return (n == CNT_MAX) ? n : n + 1'b1;
    endfunction

    // frame-end update: pull toward 0.5, then red scaling, then green pull toward 1
    function automatic logic [FW:0] next_conf(logic [FW:0] cur, logic [NW-1:0] rin,
                                              logic [NW-1:0] rout, logic [NW-1:0] gin);
        longint unsigned c;
        c = (cur > ONE) ? ONE : longint'(cur);
        if (rin == 0 && gin == 0)
            c = (9 * c + ONE / 2 + 5) / 10;
        if (rin != 0)
            c = (7 * c + 5) / 10;
        else if (rout != 0)
            c = (9 * c + 5) / 10;
        if (gin != 0)
            c = ONE - (7 * (ONE - c) + 5) / 10;
        if (c > ONE)
            c = ONE;
        return c[FW:0];
    endfunction

    function automatic logic [LEVEL_BITS-1:0] level_of(logic [FW:0] c);
        longint unsigned t;
        t = 10 * longint'(c);
        if (t > 9 * ONE) return LVL_STRONG_GO;
        if (t > 7 * ONE) return LVL_GO;
        if (t > 4 * ONE) return LVL_CAUTION;
        if (t > 3 * ONE) return LVL_STOP;
        return LVL_STRONG_STOP;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_frame_result want;
        logic          in_roi;
        if (!i_rst_n) begin
            roi_l      = 12'd256;
            roi_r      = 12'd1024;
            roi_t      = 12'd0;
            roi_b      = 12'd360;
            conf       = ONE[FW:0] >> 1;
            red_in_n   = '0;
            red_out_n  = '0;
            green_in_n = '0;
            frame_results_q.delete();
        end else begin
            // results leave before a frame end in the same cycle can be queued
            if (res_ch.valid && res_ch.ready) begin
                if (frame_results_q.size() == 0) begin
                    $error("result with no frame pending: go_confidence %0d",
                           res_ch.go_confidence);
                    fail_total++;
                end else begin
                    want = frame_results_q.pop_front();
                    check_field("go_confidence", want.conf, res_ch.go_confidence);
                    check_field("go_level", want.level, res_ch.go_level);
                    check_field("red_inside_total", want.red_tot, res_ch.red_inside_total);
                    check_field("green_inside_total", want.green_tot,
                                res_ch.green_inside_total);
                end
            end

            // a box in the same cycle as a register write sees the old region
            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.has_component && !item_ch.filtered) begin
                    in_roi = item_ch.min_x > roi_l && item_ch.max_x < roi_r &&
                             item_ch.min_y > roi_t && item_ch.max_y < roi_b;
                    if (item_ch.is_green) begin
                        if (in_roi) green_in_n = bump(green_in_n);
                    end else if (in_roi) begin
                        red_in_n = bump(red_in_n);
                    end else begin
                        red_out_n = bump(red_out_n);
                    end
                end
                if (item_ch.end_of_frame) begin
                    conf           = next_conf(conf, red_in_n, red_out_n, green_in_n);
                    want.conf      = conf;
                    want.level     = level_of(conf);
                    want.red_tot   = red_in_n;
                    want.green_tot = green_in_n;
                    frame_results_q.push_back(want);
                    red_in_n   = '0;
                    red_out_n  = '0;
                    green_in_n = '0;
                end
            end

            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_ROI_LEFT:   roi_l = cfg_ch.data;
                    REG_ROI_RIGHT:  roi_r = cfg_ch.data;
                    REG_ROI_TOP:    roi_t = cfg_ch.data;
                    REG_ROI_BOTTOM: roi_b = cfg_ch.data;
                    default: ;
                endcase
            end
        end
        o_pending    <= frame_results_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/tb_traffic_light_go_confidence_top.sv =====
// Testbench top for the go-confidence block: clock, reset, box and register
// stimulus, result back-pressure and the verdict. Depends on tlgc_pkg, tlgc_if,
// the block itself and tlgc_confidence_checker.
module tb_traffic_light_go_confidence_top;
    import tlgc_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int PHASE_ITEMS = 135;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic          has;
        logic          green;
        logic          filt;
        logic [CW-1:0] x0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y0;
        logic [CW-1:0] y1;
        logic          eof;
    } t_box_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlgc_in_if  item_ch ();
    tlgc_cfg_if cfg_ch ();
    tlgc_out_if res_ch ();

    int            fail_count;
    int            pending;
    int            items_sent = 0;
    int            idle_cycles = 0;
    int            hold_requests = 0;
    bit            sender_gaps = 1'b1;
    bit            receiver_stalls = 1'b1;
    logic [CW-1:0] win_left = 12'd256, win_right = 12'd1024;
    logic [CW-1:0] win_top = 12'd0, win_bottom = 12'd360;

    traffic_light_go_confidence_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    tlgc_confidence_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_ch      (item_ch),
        .cfg_ch       (cfg_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: long hold-off on request, random stall bursts otherwise
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_box_item mk(logic has, logic green, logic filt, int x0, int x1,
                                     int y0, int y1, logic eof);
        t_box_item it;
        it = '{has, green, filt, x0[CW-1:0], x1[CW-1:0], y0[CW-1:0], y1[CW-1:0], eof};
        return it;
    endfunction

    function automatic logic [CW-1:0] pick_between(logic [CW-1:0] lo, logic [CW-1:0] hi);
        if (hi > lo + 1)
            return CW'($urandom_range(lo + 1, hi - 1));
        return CW'($urandom_range(0, 4095));
    endfunction

    // box mostly aimed inside the window, some on its edges, some anywhere
    function automatic t_box_item random_box(int green_pct, logic eof);
        t_box_item     it;
        int            mode;
        logic [CW-1:0] tmp;
        it.has   = 1'b1;
        it.green = $urandom_range(0, 99) < green_pct;
        it.filt  = $urandom_range(0, 9) == 0;
        it.eof   = eof;
        mode     = $urandom_range(0, 9);
        if (mode <= 7) begin
            it.x0 = pick_between(win_left, win_right);
            it.x1 = pick_between(win_left, win_right);
            it.y0 = pick_between(win_top, win_bottom);
            it.y1 = pick_between(win_top, win_bottom);
            if (it.x1 < it.x0) begin
                tmp = it.x0; it.x0 = it.x1; it.x1 = tmp;
            end
            if (it.y1 < it.y0) begin
                tmp = it.y0; it.y0 = it.y1; it.y1 = tmp;
            end
            if (mode >= 6) begin
                case ($urandom_range(0, 3))
                    0: it.x0 = win_left;
                    1: it.x1 = win_right;
                    2: it.y0 = win_top;
                    default: it.y1 = win_bottom;
                endcase
            end
        end else begin
            it.x0 = CW'($urandom_range(0, 4095));
            it.x1 = CW'($urandom_range(0, 4095));
            it.y0 = CW'($urandom_range(0, 4095));
            it.y1 = CW'($urandom_range(0, 4095));
        end
        return it;
    endfunction

    // item with no box: random leftovers in the ignored fields
    function automatic t_box_item bare_item(logic eof);
        return mk(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095), eof);
    endfunction

    task automatic drive_item(t_box_item it);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.has_component <= it.has;
        item_ch.is_green      <= it.green;
        item_ch.filtered      <= it.filt;
        item_ch.min_x         <= it.x0;
        item_ch.max_x         <= it.x1;
        item_ch.min_y         <= it.y0;
        item_ch.max_y         <= it.y1;
        item_ch.end_of_frame  <= it.eof;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (it.has || it.eof)
            items_sent++;
    endtask

    // stop offering, let every frame result drain, then cover the update latency
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_roi(logic [CW-1:0] l, logic [CW-1:0] r, logic [CW-1:0] t,
                             logic [CW-1:0] b);
        logic [CW-1:0] vals[4];
        vals = '{l, r, t, b};
        for (int k = 0; k < 4; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_reg'(k);
            cfg_ch.data  <= vals[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        win_left   = l;
        win_right  = r;
        win_top    = t;
        win_bottom = b;
    endtask

    task automatic send_random_frame(int green_pct);
        int n_boxes;
        n_boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
        for (int i = 0; i < n_boxes; i++) begin
            if ($urandom_range(0, 19) == 0)
                drive_item(bare_item(1'b0));
            drive_item(random_box(green_pct, 1'b0));
        end
        if ($urandom_range(0, 1) == 0)
            drive_item(random_box(green_pct, 1'b1));
        else
            drive_item(bare_item(1'b1));
    endtask

    initial begin : stimulus
        int green_mix[5];
        int green_pct;
        int phase_end;
        int frames;
        int l, t;
        green_mix = '{20, 80, 50, 0, 100};

        i_rst_n               <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.has_component <= 1'b0;
        item_ch.is_green      <= 1'b0;
        item_ch.filtered      <= 1'b0;
        item_ch.min_x         <= '0;
        item_ch.max_x         <= '0;
        item_ch.min_y         <= '0;
        item_ch.max_y         <= '0;
        item_ch.end_of_frame  <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_ROI_LEFT;
        cfg_ch.data           <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames on the reset window 256..1024 x 0..360
        drive_item(mk(0, 0, 0, 0, 0, 0, 0, 1));             // empty frame: pull to 0.5
        drive_item(mk(0, 1, 1, 4095, 4095, 4095, 4095, 0)); // no box, no frame end
        drive_item(mk(1, 0, 0, 257, 1023, 1, 359, 0));      // red just inside
        drive_item(mk(0, 0, 0, 0, 0, 0, 0, 1));
        drive_item(mk(1, 0, 0, 256, 500, 100, 200, 0));     // each edge touched: outside
        drive_item(mk(1, 0, 0, 300, 1024, 100, 200, 0));
        drive_item(mk(1, 0, 0, 300, 500, 0, 200, 0));
        drive_item(mk(1, 0, 0, 300, 500, 100, 360, 0));
        drive_item(mk(0, 0, 0, 0, 0, 0, 0, 1));
        drive_item(mk(1, 1, 0, 400, 600, 50, 100, 1));      // green box carried on frame end
        drive_item(mk(1, 1, 0, 0, 4095, 0, 4095, 0));       // green outside: ignored
        drive_item(mk(1, 0, 1, 400, 600, 50, 100, 0));      // filtered red
        drive_item(mk(0, 0, 0, 0, 0, 0, 0, 1));
        drive_item(mk(1, 0, 0, 1000, 300, 300, 10, 0));     // min above max, passes tests
        drive_item(mk(1, 1, 0, 400, 600, 50, 100, 1));      // red and green inside
        drive_item(mk(1, 1, 0, 4095, 4095, 4095, 4095, 1));
        drive_item(mk(1, 0, 1, 0, 0, 0, 0, 1));
        for (int i = 0; i < 6; i++)
            drive_item(mk(1, 1, 0, 400, 600, 50, 100, 1));  // climb toward strong go
        for (int i = 0; i < 6; i++)
            drive_item(mk(1, 0, 0, 400, 600, 50, 100, 1));  // fall toward strong stop
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_roi(12'd256, 12'd1024, 12'd0, 12'd360);
                1: write_roi(12'd0, 12'd4095, 12'd0, 12'd4095);
                3: write_roi(12'd4095, 12'd0, 12'd4095, 12'd0);
                4: write_roi(12'd0, 12'd0, 12'd0, 12'd0);
                5: write_roi(CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)),
                             CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)));
                6: write_roi(12'd4095, 12'd4095, 12'd4095, 12'd4095);
                default: begin
                    l = $urandom_range(0, 3000);
                    t = $urandom_range(0, 3000);
                    write_roi(CW'(l), CW'($urandom_range(l + 2, 4095)), CW'(t),
                              CW'($urandom_range(t + 2, 4095)));
                end
            endcase
            sender_gaps     <= (phase != 4 && phase != 7);
            receiver_stalls <= (phase != 4 && phase != 7);

            if (phase == 0) begin
                // counters saturate well before the frame ends
                for (int i = 0; i < 265; i++) begin
                    drive_item(mk(1, 0, 0, 300, 900, 10, 300, 0));
                    drive_item(mk(1, 1, 0, 300, 900, 10, 300, 0));
                end
                drive_item(mk(1, 0, 0, 300, 900, 10, 300, 1));
            end
            if (phase == 2) begin
                // result side held off while frame ends keep coming: input must stall
                hold_requests <= hold_requests + 1;
                for (int i = 0; i < 40; i++)
                    drive_item(random_box($urandom_range(0, 100), 1'b1));
            end

            phase_end = items_sent + PHASE_ITEMS;
            frames = 0;
            green_pct = green_mix[0];
            while (items_sent < phase_end) begin
                if (frames % 6 == 0)
                    green_pct = green_mix[$urandom_range(0, 4)];
                send_random_frame(green_pct);
                frames++;
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
